// File: rtl/radix_converter_top_macros.svh
// ----------------------------------------------------------------------------
// Radix converter assertion macros
// Concurrent check helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_CONVERTER_TOP_MACROS_SVH
`define RADIX_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset
`define RC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("radix converter check failed");
// Check that a condition implies another one on the next edge
`define RC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("radix converter sequencing check failed");
`else
`define RC_ASSERT(lbl, prop)
`define RC_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// File: rtl/rc_pkg.sv
// ----------------------------------------------------------------------------
// Radix converter package
// Shared widths, the queued item type, the engine state type and digit coding.
// ----------------------------------------------------------------------------
package rc_pkg;

  // Integer bits taken from the input word and fraction digit limit
  localparam int INT_WIDTH   = 32;
  localparam int FRAC_DIGITS = 31;
  localparam int FRAC_WIDTH  = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int CHAR_WIDTH  = 7;

  // Base limits and reset value
  localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

  // Long division processes one byte of dividend per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (INT_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_WIDTH = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // Digit stack: at most INT_WIDTH integer digits (base two)
  localparam int NDIG_W = $clog2(INT_WIDTH + 1);
  localparam int SIDX_W = (INT_WIDTH > 1) ? $clog2(INT_WIDTH) : 1;
  localparam int FD_W   = $clog2(FRAC_DIGITS + 1);

  // Item queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 7'd46;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 7'd87;  // 'a' minus ten

  typedef struct packed {
    logic [INT_WIDTH-1:0]  whole;
    logic [FRAC_WIDTH-1:0] frac;
    logic [BASE_WIDTH-1:0] base;
  } rc_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rc_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_DOT,
    ST_FRAC
  } rc_state_e;

  // Map a digit value 0..35 onto 0-9a-z
  function automatic logic [CHAR_WIDTH-1:0] rc_ascii(input logic [BASE_WIDTH-1:0] dig);
    logic [CHAR_WIDTH-1:0] wide;
    wide = {{(CHAR_WIDTH-BASE_WIDTH){1'b0}}, dig};
    if (dig < 6'd10) begin
      return CHAR_ZERO + wide;
    end else begin
      return CHAR_ALPHA + wide;
    end
  endfunction

endpackage

// File: rtl/rc_front.sv
// ----------------------------------------------------------------------------
// Radix converter front end
// Holds the radix register, accepts input words and classifies them into
// queue items with a clamped base and a masked integer part.
// ----------------------------------------------------------------------------
module rc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rc_pkg::BASE_WIDTH-1:0]  cfg_wdata_i,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [63:0]                    s_data_i,
  input  rc_pkg::rc_qstat_t              qstat_i,
  output logic                           push_o,
  output rc_pkg::rc_item_t               item_o
);
  import rc_pkg::*;

  logic [BASE_WIDTH-1:0] radix_q;
  logic [BASE_WIDTH-1:0] base;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Clamp the base into range
  always_comb begin
    if (radix_q < BASE_MIN) begin
      base = BASE_MIN;
    end else if (radix_q > BASE_MAX) begin
      base = BASE_MAX;
    end else begin
      base = radix_q;
    end
  end

  // Accept whenever the queue has room
  assign s_ready_o = !qstat_i.full;
  assign push_o    = s_valid_i && !qstat_i.full;

  // Build the queue item
  always_comb begin
    item_o.whole = s_data_i[INT_WIDTH-1:0];
    item_o.frac  = s_data_i[32 +: FRAC_WIDTH];
    item_o.base  = base;
  end

endmodule

// File: rtl/rc_queue.sv
// ----------------------------------------------------------------------------
// Radix converter item queue
// Short FIFO between the front end and the conversion engine.
// ----------------------------------------------------------------------------
module rc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rc_pkg::rc_item_t  item_i,
  input  logic              pop_i,
  output rc_pkg::rc_item_t  item_o,
  output rc_pkg::rc_qstat_t qstat_o
);
  import rc_pkg::*;

  rc_item_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.valid = (cnt_q != '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && qstat_o.valid;
  assign item_o  = slot_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = do_push ? QPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = do_pop  ? QPTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/rc_back.sv
// ----------------------------------------------------------------------------
// Radix converter back end
// Divides the integer part by the base a byte per cycle, stacks the digits,
// then emits them, the dot and the fraction digits through an output register.
// ----------------------------------------------------------------------------
module rc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rc_pkg::rc_qstat_t               qstat_i,
  input  rc_pkg::rc_item_t                item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rc_pkg::CHAR_WIDTH-1:0]   out_char_o,
  output logic                            out_last_o
);
  import rc_pkg::*;
  `include "radix_converter_top_macros.svh"

  rc_state_e              state_q, state_d;
  logic [DIV_WIDTH-1:0]   dvd_q, dvd_d;
  logic [BASE_WIDTH-1:0]  rem_q, rem_d;
  logic [BASE_WIDTH-1:0]  base_q, base_d;
  logic [FRAC_WIDTH-1:0]  frac_q, frac_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [NDIG_W-1:0]      ndig_q, ndig_d;
  logic [FD_W-1:0]        fd_q, fd_d;
  logic [BASE_WIDTH-1:0]  stack_q [INT_WIDTH];
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_WIDTH-1:0]  out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic                   slot_free;
  logic                   byte_done;
  logic                   push_dig;
  logic [DIV_WIDTH-1:0]   div_q;
  logic [BASE_WIDTH-1:0]  div_r;
  logic [NDIG_W-1:0]      ndig_m1;
  logic [BASE_WIDTH-1:0]  top_dig;
  logic [FRAC_WIDTH+BASE_WIDTH-1:0] prod;
  logic                   frac_end;

  assign slot_free = !out_valid_q || out_ready_i;
  assign byte_done = (step_q == STEP_W'(DIV_STEPS - 1));
  assign ndig_m1   = NDIG_W'(ndig_q - 1'b1);
  assign top_dig   = stack_q[ndig_m1[SIDX_W-1:0]];
  assign prod      = (FRAC_WIDTH+BASE_WIDTH)'(frac_q) * (FRAC_WIDTH+BASE_WIDTH)'(base_q);
  assign frac_end  = (prod[FRAC_WIDTH-1:0] == '0) || (fd_q == FD_W'(FRAC_DIGITS - 1));

  // One byte of restoring long division
  always_comb begin
    logic [BASE_WIDTH:0]  r7;
    logic [BASE_WIDTH-1:0] r;
    logic [DIV_WIDTH-1:0] d;
    r = rem_q;
    d = dvd_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      r7 = {r, d[DIV_WIDTH-1]};
      d  = {d[DIV_WIDTH-2:0], 1'b0};
      if (r7 >= {1'b0, base_q}) begin
        r7   = r7 - {1'b0, base_q};
        d[0] = 1'b1;
      end
      r = r7[BASE_WIDTH-1:0];
    end
    div_q = d;
    div_r = r;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (qstat_i.valid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (byte_done && (div_q == '0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && (ndig_q == NDIG_W'(1))) begin
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        if (slot_free) begin
          state_d = (frac_q == '0) ? ST_IDLE : ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (slot_free && frac_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register loads
  always_comb begin
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    base_d      = base_q;
    frac_d      = frac_q;
    step_d      = step_q;
    ndig_d      = ndig_q;
    fd_d        = fd_q;
    pop_o       = 1'b0;
    push_dig    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (qstat_i.valid) begin
          pop_o  = 1'b1;
          dvd_d  = DIV_WIDTH'(item_i.whole);
          rem_d  = '0;
          base_d = item_i.base;
          frac_d = item_i.frac;
          step_d = '0;
          ndig_d = '0;
          fd_d   = '0;
        end
      end
      ST_DIV: begin
        dvd_d = div_q;
        if (byte_done) begin
          push_dig = 1'b1;
          ndig_d   = NDIG_W'(ndig_q + 1'b1);
          rem_d    = '0;
          step_d   = '0;
        end else begin
          rem_d  = div_r;
          step_d = STEP_W'(step_q + 1'b1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = rc_ascii(top_dig);
          out_last_d  = 1'b0;
          ndig_d      = ndig_m1;
        end
      end
      ST_DOT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_DOT;
          out_last_d  = (frac_q == '0);
        end
      end
      ST_FRAC: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = rc_ascii(prod[FRAC_WIDTH +: BASE_WIDTH]);
          out_last_d  = frac_end;
          frac_d      = prod[FRAC_WIDTH-1:0];
          fd_d        = FD_W'(fd_q + 1'b1);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ndig_q      <= '0;
      fd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ndig_q      <= ndig_d;
      fd_q        <= fd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    base_q     <= base_d;
    frac_q     <= frac_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (push_dig) begin
      stack_q[ndig_q[SIDX_W-1:0]] <= div_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // Checks
  `RC_ASSERT(a_stack_bound, ndig_q <= NDIG_W'(INT_WIDTH))
  `RC_ASSERT(a_frac_nonzero, (state_q != ST_FRAC) || (frac_q != '0))
  `RC_ASSERT(a_frac_count, (state_q != ST_FRAC) || (fd_q < FD_W'(FRAC_DIGITS)))
  `RC_ASSERT(a_emit_has_digit, (state_q != ST_EMIT) || (ndig_q != '0))
  `RC_ASSERT_NEXT(a_pop_starts_div, pop_o, state_q == ST_DIV)

endmodule

// File: rtl/radix_converter_top.sv
// ----------------------------------------------------------------------------
// Radix converter top level
// Converts an unsigned integer plus a Q0.32 fraction into ASCII digits in a
// configurable base, integer digits first, then '.', then fraction digits.
//
//   channel   dir   handshake             payload
//   s_axis    in    tvalid/tready         tdata[31:0] integer, [63:32] fraction
//   m_axis    out   tvalid/tready/tlast   tdata[6:0] char code, tlast last char
//   cfg       in    cfg_we_i              cfg_wdata_i radix
//
// Each integer digit comes from byte-wide long division over DIV_STEPS bytes;
// each emitted character then passes through the output register, and a
// fraction digit comes from one 32x6 multiply. A number has up to 32
// base-two integer digits and 31 fraction digits. Two input words queue
// ahead of the engine; a stalled m_axis holds the engine in its emit, dot
// and fraction states. Reset clears all control state and sets the radix to 10.
// ----------------------------------------------------------------------------
module radix_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] integer_part, [63:32] fraction_part
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast    // last_char
);
  import rc_pkg::*;

  rc_qstat_t             qstat;
  rc_item_t              front_item;
  rc_item_t              back_item;
  logic                  push;
  logic                  pop;
  logic [CHAR_WIDTH-1:0] out_char;

  rc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .qstat_i     (qstat),
    .push_o      (push),
    .item_o      (front_item)
  );

  rc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .qstat_o (qstat)
  );

  rc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (back_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  // Pad the character code to a byte
  assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: sim/tb_radix_converter_top.sv
// ----------------------------------------------------------------------------
// Radix converter testbench
// Drives numbers into radix_converter_top and checks every character word
// against digits worked out here by exact division and Q0.32 multiplication.
// It covers bases at and beyond both ends of the range and random stalls on
// both streams.
// ----------------------------------------------------------------------------
module tb_radix_converter_top;

  localparam int          HALF_PERIOD    = 5;
  localparam int          RESET_CYCLES   = 9;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          END_CYCLES     = 250;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SEGMENTS       = 6;
  localparam int          SEGMENT_ITEMS  = 33;
  localparam logic [7:0]  ASCII_ZERO     = "0";
  localparam logic [7:0]  ASCII_LC_A     = "a";
  localparam logic [7:0]  ASCII_DOT      = ".";

  // Expected characters of every accepted number, oldest first
  class char_scoreboard;
    logic [5:0]  radix;
    logic [7:0]  exp_char_q[$];
    logic        exp_last_q[$];
    int unsigned numbers;
    int unsigned chars;
    int unsigned errors;

    function new();
      radix   = rc_pkg::BASE_RESET;
      numbers = 0;
      chars   = 0;
      errors  = 0;
    endfunction

    function void set_radix(logic [5:0] value);
      radix = value;
    endfunction

    function int unsigned pending();
      return exp_char_q.size();
    endfunction

    function logic [7:0] digit_code(logic [5:0] dig);
      return (dig < 10) ? ASCII_ZERO + 8'(dig) : ASCII_LC_A + 8'(dig) - 8'd10;
    endfunction

    function void push_char(logic [7:0] code);
      exp_char_q.push_back(code);
      exp_last_q.push_back(1'b0);
    endfunction

    // Work out the characters of one accepted number
    function void note_number(logic [31:0] whole, logic [31:0] frac);
      logic [63:0] rest;
      logic [63:0] prod;
      logic [63:0] step_base;
      logic [5:0]  digits[$];
      int unsigned nfrac;
      step_base = (radix < 2) ? 64'd2 : (radix > 36) ? 64'd36 : 64'(radix);
      // integer digits, most significant first
      rest = 64'(whole) & ((64'd1 << rc_pkg::INT_WIDTH) - 64'd1);
      do begin
        digits.push_front(6'(rest % step_base));
        rest = rest / step_base;
      end while (rest != 0);
      foreach (digits[i]) push_char(digit_code(digits[i]));
      push_char(ASCII_DOT);
      // fraction digits, truncated at the digit limit
      nfrac = 0;
      rest  = 64'(frac);
      while (rest != 0 && nfrac < rc_pkg::FRAC_DIGITS) begin
        prod = rest * step_base;
        push_char(digit_code(prod[37:32]));
        rest = {32'd0, prod[31:0]};
        nfrac++;
      end
      exp_last_q[exp_last_q.size() - 1] = 1'b1;
      numbers++;
    endfunction

    // Compare one output word with the oldest expectation
    function void check_char(logic [7:0] code, logic last);
      logic [7:0] exp_code;
      logic       exp_last;
      if (exp_char_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual char 0x%02h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      exp_code = exp_char_q.pop_front();
      exp_last = exp_last_q.pop_front();
      chars++;
      if (code !== exp_code) begin
        $display("%0t: char_code mismatch: expected 0x%02h actual 0x%02h",
                 $time, exp_code, code);
        errors++;
      end
      if (last !== exp_last) begin
        $display("%0t: last_char mismatch: expected %b actual %b", $time, exp_last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] integer_part, [63:32] fraction_part
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [6:0] char_code, [7] zero
  logic        m_axis_tlast;   // last_char

  char_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned radix_writes;
  int unsigned stall_cycles = 0;

  radix_converter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one number and note it once accepted; valid stays high for the next
  task automatic send_number(input logic [31:0] whole, input logic [31:0] frac);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {frac, whole};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_number(whole, frac);
  endtask

  // Drop valid in the step of the last accept and wait for all characters
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the radix while the block is idle
  task automatic set_radix(input logic [5:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_radix(value);
    radix_writes++;
  endtask

  // Random number with a mix of sizes and fraction lengths
  task automatic send_random();
    logic [31:0] whole;
    logic [31:0] frac;
    case ($urandom_range(0, 5))
      0: begin
        whole = $urandom;
        frac  = $urandom;
      end
      1: begin
        whole = $urandom_range(0, 255);
        frac  = $urandom & 32'hF000_0000;
      end
      2: begin
        whole = $urandom;
        frac  = '0;
      end
      3: begin
        whole = $urandom >> $urandom_range(0, 31);
        frac  = $urandom >> $urandom_range(0, 31);
      end
      4: begin
        whole = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        frac  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
      end
      default: begin
        whole = $urandom;
        frac  = 32'd1 << $urandom_range(0, 31);
      end
    endcase
    send_number(whole, frac);
  endtask

  initial begin
    logic [5:0] seg_radix;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    src_idle_pct  = 16;
    dst_idle_pct  = 68;
    hold_requests = 0;
    radix_writes  = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset base ten, zero, all ones, exact and long fractions
    send_number(32'd0, 32'd0);
    send_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_number(32'd0, 32'h8000_0000);
    send_number(32'd123456789, 32'h4000_0000);
    send_number(32'd7, 32'd1);
    // Base two: the longest string and a single set bit each side
    set_radix(6'd2);
    send_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_number(32'h8000_0000, 32'd0);
    send_number(32'd0, 32'h8000_0000);
    // Base 36: top digit and the full alphabet range
    set_radix(6'd36);
    send_number(32'd35, 32'd0);
    send_number(32'hFFFF_FFFF, 32'd1);
    send_number(32'd36, 32'h0E38_E38E);
    // Radix values below the range act as base two
    set_radix(6'd0);
    send_number(32'd5, 32'h6000_0000);
    set_radix(6'd1);
    send_number(32'd9, 32'h2000_0000);
    // Radix values above the range act as base 36
    set_radix(6'd37);
    send_number(32'd35, 32'hFFFF_FFFF);
    set_radix(6'd63);
    send_number(32'd1295, 32'h1234_5678);
    // Hex letters
    set_radix(6'd16);
    send_number(32'hDEAD_BEEF, 32'hCAFE_F00D);

    // Random segments, each setting a base and an idling pattern
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) begin
        seg_radix = 6'd2;
      end else if (seg == 1) begin
        seg_radix = 6'd36;
      end else begin
        seg_radix = 6'($urandom_range(0, 63));
      end
      set_radix(seg_radix);
      if (seg < 2) begin
        src_idle_pct = 16;
        dst_idle_pct = 68;
      end else if (seg < 4) begin
        src_idle_pct = 68;
        dst_idle_pct = 16;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      // Fill the block behind a long receiver hold-off
      if (seg == 1) hold_requests++;
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_random();
    end

    // Wait out the last characters
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers into %0d checked characters over %0d radix settings,",
             sb.numbers, sb.chars, radix_writes + 1);
    $display("bases two to 36 and out-of-range values, with stalls on both streams.");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: radix_converter_top.f
+incdir+rtl
rtl/rc_pkg.sv
rtl/rc_front.sv
rtl/rc_queue.sv
rtl/rc_back.sv
rtl/radix_converter_top.sv
sim/tb_radix_converter_top.sv
